// ----- sv/ppa_pkg.sv -----
// ppa_pkg: shared types and constants for the parser pool allocator
// beat payload structs, per-cell status struct and default sizes
// no dependencies
`timescale 1ns / 1ps

package ppa_pkg;

    // default pool shape
    localparam int NUM_REQUESTERS_DEF = 4;
    localparam int NUM_PARSERS_DEF    = 4;

    // fixed report widths of the beat fields
    localparam int MASK_W     = 4;
    localparam int SLOT_W     = 2;
    localparam int ASSIGN_W   = MASK_W * SLOT_W;

    // input beat: one clock tick of requester activity
    typedef struct packed {
        logic [MASK_W-1:0] request_valid_mask;
        logic [MASK_W-1:0] request_done_mask;
    } ppa_in_t;

    // result beat: grants and pool state after the tick
    typedef struct packed {
        logic [MASK_W-1:0]   grant_mask;
        logic [MASK_W-1:0]   serving_mask;
        logic [MASK_W-1:0]   parser_idle_mask;
        logic [ASSIGN_W-1:0] assignment_vector;
    } ppa_out_t;

    // status handed from a requester cell to the top level
    typedef struct packed {
        logic held;     // serving before this tick
        logic serving;  // serving after this tick
        logic grant;    // won a parser in this tick
    } ppa_cell_stat_t;

endpackage

// ----- sv/ppa_cell.sv -----
// ppa_cell: one requester slot of the allocator chain
// releases its parser on done, takes the lowest free parser on valid
// depends on ppa_pkg
`timescale 1ns / 1ps

module ppa_cell import ppa_pkg::*; #(
    parameter int NUM_PARSERS = NUM_PARSERS_DEF,
    parameter int PIDX_W      = (NUM_PARSERS > 1) ? $clog2(NUM_PARSERS) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic                   req_valid,
    input  logic                   req_done,
    input  logic [NUM_PARSERS-1:0] free_in,
    output logic [NUM_PARSERS-1:0] free_out,
    output ppa_cell_stat_t         stat,
    output logic [PIDX_W-1:0]      link_idx
);

    logic                   serving_reg;
    logic                   serving_next;
    logic [PIDX_W-1:0]      link_reg;
    logic [PIDX_W-1:0]      link_next;

    logic                   release_hit;
    logic [NUM_PARSERS-1:0] link_onehot;
    logic [NUM_PARSERS-1:0] free_mid;
    logic [NUM_PARSERS-1:0] pick_onehot;
    logic [PIDX_W-1:0]      pick_idx;
    logic                   pick_found;
    logic                   take;

    // release first, then look for the lowest free parser
    always_comb begin
        release_hit = serving_reg && req_done;
        for (int p = 0; p < NUM_PARSERS; p++) begin
            link_onehot[p] = (link_reg == PIDX_W'(p));
        end
        free_mid = free_in | (release_hit ? link_onehot : '0);

        pick_idx    = '0;
        pick_found  = 1'b0;
        pick_onehot = '0;
        for (int p = NUM_PARSERS - 1; p >= 0; p--) begin
            if (free_mid[p]) begin
                pick_idx    = PIDX_W'(p);
                pick_found  = 1'b1;
                pick_onehot = NUM_PARSERS'(1) << p;
            end
        end

        take     = req_valid && !(serving_reg && !release_hit) && pick_found;
        free_out = free_mid & ~(take ? pick_onehot : '0);

        serving_next = (serving_reg && !release_hit) || take;
        if (take) begin
            link_next = pick_idx;
        end else if (release_hit) begin
            link_next = '0;
        end else begin
            link_next = link_reg;
        end
    end

    // per-requester state, advanced once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serving_reg <= 1'b0;
            link_reg    <= '0;
        end else if (step_en) begin
            serving_reg <= serving_next;
            link_reg    <= link_next;
        end
    end

    assign stat.held    = serving_reg;
    assign stat.serving = serving_next;
    assign stat.grant   = take;
    assign link_idx     = link_next;

endmodule

// ----- sv/parser_pool_allocator.sv -----
// parser_pool_allocator: fixed-priority allocator of a parser pool to requesters
// chain of ppa_cell instances with an idle-vector register and a two-entry result buffer
// depends on ppa_pkg and ppa_cell
`timescale 1ns / 1ps

// One input beat is one clock tick of requester activity; one result beat
// comes back for each. The block takes one beat every cycle and returns its
// result through an output register backed by a skid entry, so input is
// only held off when both are full. Within a beat the free-parser vector
// ripples combinationally from requester 0 upward through the cell chain:
// a lower requester releases or claims first, and a parser freed low in the
// chain may be claimed higher up in the same tick. Only requesters and
// parsers 0 to 3 appear in the result fields; parser indices are reported
// in two bits per requester and read as zero where not serving.

module parser_pool_allocator import ppa_pkg::*; #(
    parameter int NUM_REQUESTERS = NUM_REQUESTERS_DEF,
    parameter int NUM_PARSERS    = NUM_PARSERS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ppa_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output ppa_out_t m_payload
);

    localparam int PIDX_W = (NUM_PARSERS > 1) ? $clog2(NUM_PARSERS) : 1;

    logic                   accept;
    logic [NUM_PARSERS-1:0] idle_reg;
    logic [NUM_PARSERS-1:0] free_chain [NUM_REQUESTERS+1];
    ppa_cell_stat_t         cell_stat  [NUM_REQUESTERS];
    logic [PIDX_W-1:0]      cell_link  [NUM_REQUESTERS];
    logic [NUM_REQUESTERS-1:0] held_vec;
    ppa_out_t               result;

    ppa_out_t out_reg;
    logic     out_valid_reg;
    ppa_out_t skid_reg;
    logic     skid_valid_reg;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // requester cells, free vector handed up the chain
    assign free_chain[0] = idle_reg;

    for (genvar r = 0; r < NUM_REQUESTERS; r++) begin : g_cell
        logic req_valid;
        logic req_done;

        if (r < MASK_W) begin : g_in
            assign req_valid = s_payload.request_valid_mask[r];
            assign req_done  = s_payload.request_done_mask[r];
        end else begin : g_none
            assign req_valid = 1'b0;
            assign req_done  = 1'b0;
        end

        ppa_cell #(
            .NUM_PARSERS (NUM_PARSERS),
            .PIDX_W      (PIDX_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step_en   (accept),
            .req_valid (req_valid),
            .req_done  (req_done),
            .free_in   (free_chain[r]),
            .free_out  (free_chain[r+1]),
            .stat      (cell_stat[r]),
            .link_idx  (cell_link[r])
        );

        assign held_vec[r] = cell_stat[r].held;
    end

    // pool idle vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg <= '1;
        end else if (accept) begin
            idle_reg <= free_chain[NUM_REQUESTERS];
        end
    end

    // result fields, reported slots only
    for (genvar r = 0; r < MASK_W; r++) begin : g_rep_req
        if (r < NUM_REQUESTERS) begin : g_on
            logic [PIDX_W+SLOT_W-1:0] link_ext;
            assign link_ext = {{SLOT_W{1'b0}}, cell_link[r]};
            assign result.grant_mask[r]   = cell_stat[r].grant;
            assign result.serving_mask[r] = cell_stat[r].serving;
            assign result.assignment_vector[SLOT_W*r +: SLOT_W] =
                cell_stat[r].serving ? link_ext[SLOT_W-1:0] : '0;
        end else begin : g_off
            assign result.grant_mask[r]   = 1'b0;
            assign result.serving_mask[r] = 1'b0;
            assign result.assignment_vector[SLOT_W*r +: SLOT_W] = '0;
        end
    end

    for (genvar p = 0; p < MASK_W; p++) begin : g_rep_par
        if (p < NUM_PARSERS) begin : g_on
            assign result.parser_idle_mask[p] = free_chain[NUM_REQUESTERS][p];
        end else begin : g_off
            assign result.parser_idle_mask[p] = 1'b0;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= result;
            end
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

`ifndef ASSERT_OFF
    // serving requesters plus idle parsers always add up to the pool size
    a_pool_conserved: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(held_vec) + $countones(idle_reg)) == NUM_PARSERS)
        else $error("parser pool count mismatch");

    // a granted requester is serving in the same beat
    a_grant_serving: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_payload.grant_mask & ~m_payload.serving_mask) == '0))
        else $error("grant without serving");

    // skid entry only fills behind a stalled output register
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // requester 0 is granted only if it was not serving or releases in the same beat
    a_no_regrant: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !(result.grant_mask[0] && held_vec[0]
                     && !s_payload.request_done_mask[0]))
        else $error("requester 0 granted while serving");
`endif

endmodule
